/* hw/rtl/gpds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy power-denomination split: shared definitions
// Field widths, configuration register indexes, parameter defaults and the
// status record of the shared divider.
// ----------------------------------------------------------------------------
package gpds_pkg;

    // Default width of the amount that is actually split.
    localparam int AMOUNT_BITS_DEF = 32;

    // Fixed field widths of the stream and configuration ports.
    localparam int FIELD_W  = 32;
    localparam int RADIX_W  = 16;
    localparam int TOPEXP_W = 5;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_EXP = 1'd1;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* hw/rtl/gpds_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy power-denomination split: shared divider
// Restoring divider that retires one quotient bit per cycle and returns both
// the quotient and the remainder.
// ----------------------------------------------------------------------------
module gpds_div #(
    parameter int W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [W-1:0]        i_dividend,
    input  logic [W-1:0]        i_divisor,
    output logic [W-1:0]        o_quot,
    output logic [W-1:0]        o_rem,
    output gpds_pkg::t_div_stat o_stat
);
    import gpds_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_q;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [W:0]    partial;
    logic          ge;
    logic [W:0]    diff;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign partial = {r_rem, r_q[W-1]};
    assign ge      = (partial >= {1'b0, r_d});
    assign diff    = partial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[W-2:0], ge};
            r_rem <= ge ? diff[W-1:0] : partial[W-1:0];
        end
    end

    assign o_quot      = r_q;
    assign o_rem       = r_rem;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

/* hw/rtl/greedy_power_denomination_split_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy power-denomination split: top level
// Splits each amount greedily into powers of a configurable radix and streams
// out one request per used denomination, followed by a total request.
// ----------------------------------------------------------------------------
// One amount is taken at a time. The block first climbs the powers of the
// radix with one multiply and one compare per step until the next power
// would exceed the amount or the top exponent is reached, keeping every
// power in a small table. It then walks back down: for each power that fits
// into what is left, a single shared restoring divider yields the count and
// the new remainder. Each result leaves through an output register, so a
// finished total can wait downstream while the next amount is already
// accepted. A radix below two acts as two. Configuration must be written
// only while idle.
// ----------------------------------------------------------------------------
module greedy_power_denomination_split_top #(
    parameter int AMOUNT_BITS = gpds_pkg::AMOUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [gpds_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gpds_pkg::RADIX_W-1:0]    i_cfg_data,
    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,   // [31:0] amount
    // Output stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [63:0]                     m_axis_tdata,   // [31:0] denomination, [63:32] count
    output logic                            m_axis_tuser,   // [0] is_total
    output logic                            m_axis_tlast    // last request of the run
);
    import gpds_pkg::*;

    // The amount field is 32 bits, so no more than that can be split.
    localparam int RW    = (AMOUNT_BITS < FIELD_W) ? AMOUNT_BITS : FIELD_W;
    localparam int PW    = RW + RADIX_W;
    localparam int DEPTH = 1 << TOPEXP_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_CHK   = 4'd2;
    localparam logic [3:0] ST_DESC  = 4'd3;
    localparam logic [3:0] ST_DIVW  = 4'd4;
    localparam logic [3:0] ST_EMIT  = 4'd5;
    localparam logic [3:0] ST_NEXT  = 4'd6;
    localparam logic [3:0] ST_LOAD  = 4'd7;
    localparam logic [3:0] ST_TOTAL = 4'd8;

    // Configuration registers.
    logic [RADIX_W-1:0]  r_radix;
    logic [TOPEXP_W-1:0] r_top_exp;
    logic [RADIX_W-1:0]  radix_eff;

    // Sequencer state.
    logic [3:0]          r_state, n_state;
    logic [RW-1:0]       r_left, n_left;
    logic [RW-1:0]       r_pow, n_pow;
    logic [TOPEXP_W-1:0] r_exp, n_exp;
    logic [RW-1:0]       r_tot, n_tot;
    logic [PW-1:0]       r_prod;

    // Power table: one write and one registered read per cycle.
    logic [RW-1:0]       r_pow_mem [DEPTH];
    logic [RW-1:0]       r_rd_data;
    logic                mem_we;
    logic [TOPEXP_W-1:0] mem_waddr;
    logic [RW-1:0]       mem_wdata;

    // Output register.
    logic                r_o_valid, n_o_valid;
    logic [RW-1:0]       r_o_denom, n_o_denom;
    logic [RW-1:0]       r_o_count, n_o_count;
    logic                r_o_total, n_o_total;
    logic                slot_free;

    // Shared divider.
    logic                div_start;
    logic [RW-1:0]       div_quot;
    logic [RW-1:0]       div_rem;
    t_div_stat           div_stat;

    assign radix_eff = (r_radix < RADIX_W'(2)) ? RADIX_W'(2) : r_radix;
    assign slot_free = !r_o_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix   <= RADIX_W'(10);
            r_top_exp <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RADIX:   r_radix   <= i_cfg_data;
                CFG_TOP_EXP: r_top_exp <= i_cfg_data[TOPEXP_W-1:0];
                default: ;
            endcase
        end
    end

    gpds_div #(
        .W (RW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_left),
        .i_divisor  (r_pow),
        .o_quot     (div_quot),
        .o_rem      (div_rem),
        .o_stat     (div_stat)
    );

    always_comb begin
        n_state   = r_state;
        n_left    = r_left;
        n_pow     = r_pow;
        n_exp     = r_exp;
        n_tot     = r_tot;
        n_o_valid = r_o_valid && !m_axis_tready;
        n_o_denom = r_o_denom;
        n_o_count = r_o_count;
        n_o_total = r_o_total;
        mem_we    = 1'b0;
        mem_waddr = r_exp + 1'b1;
        mem_wdata = r_prod[RW-1:0];
        div_start = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_left    = s_axis_tdata[RW-1:0];
                    n_pow     = RW'(1);
                    n_exp     = '0;
                    n_tot     = '0;
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = RW'(1);
                    n_state   = ST_MUL;
                end
            end
            ST_MUL: begin
                // Climb no further than the top exponent.
                n_state = (r_exp == r_top_exp) ? ST_DESC : ST_CHK;
            end
            ST_CHK: begin
                // The next power is used only if it still fits in the amount.
                if (r_prod <= PW'(r_left)) begin
                    n_pow   = r_prod[RW-1:0];
                    n_exp   = r_exp + 1'b1;
                    mem_we  = 1'b1;
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_DESC;
                end
            end
            ST_DESC: begin
                if (r_pow <= r_left) begin
                    div_start = 1'b1;
                    n_state   = ST_DIVW;
                end else begin
                    n_state = ST_NEXT;
                end
            end
            ST_DIVW: begin
                if (div_stat.done) begin
                    n_left  = div_rem;
                    n_tot   = r_tot + div_quot;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_o_valid = 1'b1;
                    n_o_denom = r_pow;
                    n_o_count = div_quot;
                    n_o_total = 1'b0;
                    n_state   = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (r_exp == '0) begin
                    n_state = ST_TOTAL;
                end else begin
                    n_exp   = r_exp - 1'b1;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_pow   = r_rd_data;
                n_state = ST_DESC;
            end
            ST_TOTAL: begin
                if (slot_free) begin
                    n_o_valid = 1'b1;
                    n_o_denom = '0;
                    n_o_count = r_tot;
                    n_o_total = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left    <= n_left;
        r_pow     <= n_pow;
        r_exp     <= n_exp;
        r_tot     <= n_tot;
        r_o_denom <= n_o_denom;
        r_o_count <= n_o_count;
        r_o_total <= n_o_total;
        r_prod    <= PW'(r_pow) * PW'(radix_eff);
    end

    // The read in the step state fetches the power one exponent lower.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_pow_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_pow_mem[r_exp - 1'b1];
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {FIELD_W'(r_o_count), FIELD_W'(r_o_denom)};
    assign m_axis_tuser  = r_o_total;
    assign m_axis_tlast  = r_o_total;

endmodule

/* verif/greedy_power_denomination_split_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy power-denomination split: testbench
// Sends amounts through the input stream under several radix and top exponent
// settings and predicts every denomination request and the closing total
// request. Each result is checked field by field as it leaves the block, and
// both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module greedy_power_denomination_split_top_tb;
    import gpds_pkg::*;

    // One result request as it appears on the output stream.
    typedef struct packed {
        logic [FIELD_W-1:0] denomination;
        logic [FIELD_W-1:0] count;
        logic               is_total;
        logic               last;
    } t_split_req;

    // A power that no amount can reach, so it is never used as a denomination.
    localparam logic [63:0] POWER_CEIL = 64'h8000_0000_0000_0000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [RADIX_W-1:0]   i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata;   // [31:0] amount
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [63:0]          m_axis_tdata;   // [31:0] denomination, [63:32] count
    logic                 m_axis_tuser;   // [0] is_total
    logic                 m_axis_tlast;

    // Local copy of the configuration as the block should hold it.
    logic [RADIX_W-1:0]   radix_cfg;
    logic [TOPEXP_W-1:0]  top_exp_cfg;

    // Requests still owed by the block, oldest first.
    t_split_req           pending_splits[$];

    // Stimulus controls for the sender and the result sink.
    bit                   src_idle_en;
    bit                   sink_idle_en;
    int                   sink_hold_cycles;

    int                   amounts_sent;
    int                   reqs_checked;
    int                   totals_seen;
    int                   settings_used;
    int                   error_count;

    greedy_power_denomination_split_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 20 ns clock period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Works out the requests one amount must produce under the current
    // configuration. The power table saturates at POWER_CEIL before a product
    // can overflow, and powers above any 32-bit amount simply never fit.
    function automatic void predict_split(input logic [31:0] amount);
        logic [63:0] base;
        logic [63:0] powers[32];
        logic [63:0] left;
        logic [63:0] pieces;
        logic [31:0] pieces_sum;
        t_split_req  req;
        base = (radix_cfg < 2) ? 64'd2 : 64'(radix_cfg);
        powers[0] = 64'd1;
        for (int k = 1; k < 32; k++)
            powers[k] = (powers[k-1] > POWER_CEIL / base) ? POWER_CEIL : powers[k-1] * base;
        left = 64'(amount);
        pieces_sum = '0;
        for (int k = int'(top_exp_cfg); k >= 0; k--) begin
            if (powers[k] <= left) begin
                pieces = left / powers[k];
                left = left - pieces * powers[k];
                pieces_sum = pieces_sum + pieces[31:0];
                req.denomination = powers[k][31:0];
                req.count        = pieces[31:0];
                req.is_total     = 1'b0;
                req.last         = 1'b0;
                pending_splits.push_back(req);
            end
        end
        req.denomination = '0;
        req.count        = pieces_sum;
        req.is_total     = 1'b1;
        req.last         = 1'b1;
        pending_splits.push_back(req);
    endfunction

    // Offers one amount, with an optional random gap first, and returns at
    // the edge that takes it. The caller must follow with another send or a
    // release so the same request is not taken twice.
    task automatic send_amount(input logic [31:0] amount);
        int gap;
        gap = src_idle_en ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= amount;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_split(amount);
        amounts_sent++;
    endtask

    // Drops the input valid and waits until every owed request has left.
    // Every amount ends in a total request, so the block is idle afterwards;
    // a few spare cycles are still allowed.
    task automatic drain_splits();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_splits.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Register writes only happen while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RADIX_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_RADIX)
            radix_cfg = value;
        else if (idx == CFG_TOP_EXP)
            top_exp_cfg = value[TOPEXP_W-1:0];
    endtask

    task automatic set_split(input logic [RADIX_W-1:0] radix, input logic [TOPEXP_W-1:0] top_exp);
        write_reg(CFG_RADIX, radix);
        write_reg(CFG_TOP_EXP, RADIX_W'(top_exp));
        settings_used++;
    endtask

    // Amounts of mixed shape: full random, shortened, tiny, and runs of ones.
    function automatic logic [31:0] random_amount();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom >> $urandom_range(1, 31);
            2:       return $urandom_range(0, 1000);
            default: return 32'hFFFF_FFFF >> $urandom_range(0, 31);
        endcase
    endfunction

    // Nothing written yet: radix ten and a top exponent of zero, so every
    // nonzero amount comes back as a single count of ones.
    task automatic test_reset_defaults();
        send_amount(32'd0);
        send_amount(32'd1);
        send_amount(32'd9);
        send_amount(32'hFFFF_FFFF);
        drain_splits();
    endtask

    // Field extremes, a zero amount, radix zero and one acting as two, the
    // widest radix whose upper powers saturate, and the deepest exponent.
    task automatic test_directed_corners();
        set_split(16'd10, 5'd9);
        send_amount(32'd0);
        send_amount(32'd1234567890);
        send_amount(32'hFFFF_FFFF);
        drain_splits();
        set_split(16'd0, 5'd31);
        send_amount(32'hFFFF_FFFF);
        send_amount(32'h8000_0000);
        drain_splits();
        set_split(16'd1, 5'd31);
        send_amount(32'h5555_5555);
        send_amount(32'd0);
        drain_splits();
        set_split(16'hFFFF, 5'd31);
        send_amount(32'hFFFF_FFFF);
        send_amount(32'hFFFE_0001);
        send_amount(32'd65534);
        drain_splits();
        set_split(16'd3, 5'd20);
        send_amount(32'hFFFF_FFFF);
        send_amount(32'd3486784401);
        drain_splits();
        set_split(16'd16, 5'd7);
        send_amount(32'hFFFF_FFFF);
        drain_splits();
    endtask

    // Random phases, each under a fresh setting. One phase runs with no
    // idling on either side.
    task automatic test_random_phases();
        logic [RADIX_W-1:0]  radix;
        logic [TOPEXP_W-1:0] top_exp;
        for (int phase = 0; phase < 7; phase++) begin
            case ($urandom_range(0, 5))
                0:       radix = 16'd2;
                1:       radix = 16'd10;
                2:       radix = 16'hFFFF;
                3:       radix = RADIX_W'($urandom_range(0, 300));
                default: radix = RADIX_W'($urandom);
            endcase
            case ($urandom_range(0, 2))
                0:       top_exp = 5'd0;
                1:       top_exp = 5'd31;
                default: top_exp = TOPEXP_W'($urandom);
            endcase
            set_split(radix, top_exp);
            src_idle_en  = (phase != 3);
            sink_idle_en = (phase != 3);
            repeat (35) send_amount(random_amount());
            drain_splits();
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // The receiver holds off for a long stretch while amounts keep coming,
    // so the output register fills and the input stalls.
    task automatic test_output_holdoff();
        set_split(16'd10, 5'd9);
        src_idle_en = 1'b0;
        sink_hold_cycles = 2500;
        repeat (6) send_amount($urandom);
        src_idle_en = 1'b1;
        drain_splits();
    endtask

    // The sender pauses mid-stream until every owed request has come back.
    task automatic test_sender_pause();
        set_split(16'd7, 5'd12);
        repeat (5) send_amount(random_amount());
        drain_splits();
        repeat (5) send_amount(random_amount());
        drain_splits();
    endtask

    // Result sink: random stalls, or a long hold-off when one is asked for.
    initial begin : result_sink
        int n;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_cycles > 0) begin
                n = sink_hold_cycles;
                sink_hold_cycles = 0;
                m_axis_tready <= 1'b0;
                repeat (n) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (sink_idle_en && $urandom_range(0, 99) < 30) begin
                n = pick_gap();
                m_axis_tready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Each accepted request is compared with the oldest one owed.
    always @(posedge i_clk) begin : result_check
        t_split_req want;
        t_split_req got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.denomination = m_axis_tdata[31:0];
            got.count        = m_axis_tdata[63:32];
            got.is_total     = m_axis_tuser;
            got.last         = m_axis_tlast;
            reqs_checked++;
            if (got.is_total)
                totals_seen++;
            if (pending_splits.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected request: denom=%0d count=%0d total=%0b last=%0b",
                             got.denomination, got.count, got.is_total, got.last);
            end else begin
                want = pending_splits.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("request %0d mismatch: ", reqs_checked,
                                 "expected denom=%0d count=%0d total=%0b last=%0b, ",
                                 want.denomination, want.count, want.is_total, want.last,
                                 "got denom=%0d count=%0d total=%0b last=%0b",
                                 got.denomination, got.count, got.is_total, got.last);
                end
            end
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #100_000_000;
        $display("timeout waiting on the block");
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_RADIX;
        i_cfg_data       = '0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        radix_cfg        = 16'd10;
        top_exp_cfg      = 5'd0;
        src_idle_en      = 1'b1;
        sink_idle_en     = 1'b1;
        sink_hold_cycles = 0;
        amounts_sent     = 0;
        reqs_checked     = 0;
        totals_seen      = 0;
        settings_used    = 1;
        error_count      = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_corners();
        test_random_phases();
        test_output_holdoff();
        test_sender_pause();

        repeat (50) @(posedge i_clk);
        if (pending_splits.size() != 0)
            error_count++;
        $display("Split %0d amounts into %0d requests (%0d totals) over %0d radix settings,",
                 amounts_sent, reqs_checked, totals_seen, settings_used);
        $display("with random stalls on both streams, a long output hold-off and a sender pause.");
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
